/* rtl/mgfa_pkg.sv */
// Shared types, constants and lookup functions of the mode-gated fault annunciator.
package mgfa_pkg;

   localparam int NUM_CODES    = 27;
   localparam int NUM_CHECKS   = 17;
   localparam int JOB_DEPTH    = 2;

   // path and shutdown latches never clear
   localparam logic [NUM_CODES-1:0] STICKY_MASK = 27'h001CFFF;

   // check indexes, in check order
   localparam int CHK_CMD  = 0;
   localparam int CHK_DATA = 1;
   localparam int CHK_ELEC = 2;
   localparam int CHK_HYD  = 3;
   localparam int CHK_OTT  = 4;
   localparam int CHK_ROLL = 5;
   localparam int CHK_SSME = 6;
   localparam int CHK_MEP  = 7;
   localparam int CHK_SEP  = 8;
   localparam int CHK_DAP  = 9;
   localparam int CHK_FCS  = 10;
   localparam int CHK_SPD  = 11;
   localparam int CHK_TDT  = 12;
   localparam int CHK_LOMS = 15;
   localparam int CHK_ROMS = 16;

   // message codes
   localparam int CODE_DATA = 3;
   localparam int CODE_ELEC = 6;
   localparam int CODE_HYD  = 9;
   localparam int CODE_OTT  = 12;
   localparam int CODE_ROLL = 13;
   localparam int CODE_SSME = 14;
   localparam int CODE_MEP  = 17;
   localparam int CODE_SEP  = 18;
   localparam int CODE_DAP  = 19;
   localparam int CODE_FCS  = 20;
   localparam int CODE_SPD  = 21;
   localparam int CODE_TGT  = 22;
   localparam int CODE_LOMS = 25;
   localparam int CODE_ROMS = 26;

   localparam logic [1:0] CLASS_CAUTION = 2'd2;
   localparam logic [1:0] CLASS_WARNING = 2'd3;

   localparam logic [1:0] SAT_LOW    = 2'd0;
   localparam logic [1:0] SAT_HIGH   = 2'd1;
   localparam logic [1:0] SAT_WITHIN = 2'd2;
   localparam logic [1:0] SAT_NONE   = 2'd3;

   localparam logic [9:0] MODE_305 = 10'd305;
   localparam logic [9:0] MODE_603 = 10'd603;

   localparam logic [15:0] HIGH_LIMIT_RESET = 16'sd1536;
   localparam logic [15:0] LOW_LIMIT_RESET  = 16'hF880;   // -1920

   localparam logic CSR_HIGH_LIMIT = 1'b0;
   localparam logic CSR_LOW_LIMIT  = 1'b1;

   // one classified monitoring cycle waiting for the back end
   typedef struct packed {
      logic [NUM_CODES-1:0] post_mask;
      logic [2:0]           fill_in;
      logic [1:0]           sat_lo;
      logic [1:0]           sat_li;
      logic [1:0]           sat_ri;
      logic [1:0]           sat_ro;
      logic [1:0]           disc;
   } job_type;

   // one result transaction
   typedef struct packed {
      logic       msg_valid;
      logic [4:0] msg_code;
      logic [1:0] msg_class;
      logic [2:0] msg_slot;
      logic [2:0] queue_fill_out;
      logic [1:0] sat_lo;
      logic [1:0] sat_li;
      logic [1:0] sat_ri;
      logic [1:0] sat_ro;
      logic [1:0] disc;
      logic       last;
   } rsp_type;

   // checks enabled in each major mode
   function automatic logic [NUM_CHECKS-1:0] mode_checks(input logic [9:0] mm);
      logic [NUM_CHECKS-1:0] m;
      case (mm)
         10'd101: m = 17'h0009F;
         10'd102, 10'd103: m = 17'h001DF;
         10'd104: m = 17'h18193;
         10'd105, 10'd106: m = 17'h18090;
         10'd201: m = 17'h07000;
         10'd202: m = 17'h1F000;
         10'd301, 10'd302, 10'd303: m = 17'h184B0;
         10'd304: m = 17'h18EB0;
         10'd305: m = 17'h00EB0;
         10'd601: m = 17'h000DF;
         10'd602, 10'd603: m = 17'h00E90;
         default: m = '0;
      endcase
      return m;
   endfunction

   // caution and warning class of a message code
   function automatic logic [1:0] code_class(input logic [4:0] code);
      logic [1:0] c;
      case (code)
         5'(CODE_SSME), 5'(CODE_SSME + 1), 5'(CODE_SSME + 2), 5'(CODE_FCS),
         5'(CODE_LOMS), 5'(CODE_ROMS): c = CLASS_CAUTION;
         default: c = CLASS_WARNING;
      endcase
      return c;
   endfunction

endpackage

/* rtl/mgfa_front.sv */
// Front end: limit registers, alert latches and classification of each monitoring cycle.
module mgfa_front
   import mgfa_pkg::*;
#(
   parameter int QUEUE_SLOTS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wr_data,
   input  logic        accept,
   input  logic [9:0]  major_mode,
   input  logic [12:0] alert_bits,
   input  logic [11:0] engine_path_bits,
   input  logic [2:0]  engine_shutdown_bits,
   input  logic        meco_commanded,
   input  logic        weight_on_wheels,
   input  logic signed [15:0] pos_left_outboard,
   input  logic signed [15:0] pos_left_inboard,
   input  logic signed [15:0] pos_right_inboard,
   input  logic signed [15:0] pos_right_outboard,
   input  logic [2:0]  queue_fill_in,
   output job_type     job
);

   logic signed [15:0]   high_limit_ff, low_limit_ff;
   logic [NUM_CODES-1:0] latches_ff, latches_in;
   logic [NUM_CODES-1:0] en, active, rising;
   logic [NUM_CHECKS-1:0] chk;
   logic                 gated, sat_run, sat_any, room;
   logic [1:0]           st_lo, st_li, st_ri, st_ro;

   // per-surface saturation status
   function automatic logic [1:0] sat_of(input logic signed [15:0] p,
                                         input logic signed [15:0] hi,
                                         input logic signed [15:0] lo);
      logic [1:0] s;
      if (p > hi) s = SAT_HIGH;
      else if (p < lo) s = SAT_LOW;
      else s = SAT_WITHIN;
      return s;
   endfunction

   // hold the limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         high_limit_ff <= HIGH_LIMIT_RESET;
         low_limit_ff  <= LOW_LIMIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_HIGH_LIMIT: high_limit_ff <= csr_wr_data;
            CSR_LOW_LIMIT:  low_limit_ff  <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // enable, activity and edge detection for every message code
   always_comb begin
      chk     = mode_checks(major_mode);
      gated   = ((major_mode == MODE_305) || (major_mode == MODE_603)) && weight_on_wheels;
      sat_run = chk[CHK_FCS] && !gated;

      st_lo = sat_run ? sat_of(pos_left_outboard,  high_limit_ff, low_limit_ff) : SAT_NONE;
      st_li = sat_run ? sat_of(pos_left_inboard,   high_limit_ff, low_limit_ff) : SAT_NONE;
      st_ri = sat_run ? sat_of(pos_right_inboard,  high_limit_ff, low_limit_ff) : SAT_NONE;
      st_ro = sat_run ? sat_of(pos_right_outboard, high_limit_ff, low_limit_ff) : SAT_NONE;
      sat_any = (st_lo == SAT_HIGH) || (st_lo == SAT_LOW) || (st_li == SAT_HIGH) ||
                (st_li == SAT_LOW) || (st_ri == SAT_HIGH) || (st_ri == SAT_LOW) ||
                (st_ro == SAT_HIGH) || (st_ro == SAT_LOW);

      en     = '0;
      active = '0;
      for (int e = 0; e < 3; e++) begin
         en[e]             = chk[CHK_CMD];
         en[CODE_DATA + e] = chk[CHK_DATA];
         en[CODE_ELEC + e] = chk[CHK_ELEC];
         en[CODE_HYD + e]  = chk[CHK_HYD];
         en[CODE_SSME + e] = chk[CHK_SSME] && !meco_commanded;
         en[CODE_TGT + e]  = chk[CHK_TDT + e];
         active[CODE_SSME + e] = engine_shutdown_bits[e];
         active[CODE_TGT + e]  = alert_bits[6 + e];
      end
      active[CODE_OTT-1:0] = engine_path_bits;
      en[CODE_OTT]  = chk[CHK_OTT];   active[CODE_OTT]  = alert_bits[1];
      en[CODE_ROLL] = chk[CHK_ROLL];  active[CODE_ROLL] = alert_bits[2];
      en[CODE_MEP]  = chk[CHK_MEP];   active[CODE_MEP]  = alert_bits[3];
      en[CODE_SEP]  = chk[CHK_SEP];   active[CODE_SEP]  = alert_bits[0];
      en[CODE_DAP]  = chk[CHK_DAP];   active[CODE_DAP]  = alert_bits[4];
      en[CODE_FCS]  = sat_run;        active[CODE_FCS]  = sat_any;
      en[CODE_SPD]  = chk[CHK_SPD];   active[CODE_SPD]  = alert_bits[5];
      en[CODE_LOMS] = chk[CHK_LOMS];  active[CODE_LOMS] = |alert_bits[10:9];
      en[CODE_ROMS] = chk[CHK_ROMS];  active[CODE_ROMS] = |alert_bits[12:11];

      // set on an active check, clear a non-sticky one when its condition is gone
      for (int c = 0; c < NUM_CODES; c++) begin
         rising[c] = en[c] && active[c] && !latches_ff[c];
         if (en[c] && active[c]) latches_in[c] = 1'b1;
         else if (en[c] && !STICKY_MASK[c]) latches_in[c] = 1'b0;
         else latches_in[c] = latches_ff[c];
      end

      room = ({5'd0, queue_fill_in} < 8'(QUEUE_SLOTS));

      job.post_mask = room ? rising : '0;
      job.fill_in   = queue_fill_in;
      job.sat_lo    = st_lo;
      job.sat_li    = st_li;
      job.sat_ri    = st_ri;
      job.sat_ro    = st_ro;
      job.disc      = {latches_in[CODE_FCS], latches_in[CODE_LOMS] | latches_in[CODE_ROMS]};
   end

   // advance the latches on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) latches_ff <= '0;
      else if (accept) latches_ff <= latches_in;
   end

endmodule

/* rtl/mgfa_fifo.sv */
// Short job queue between the front and back ends.
module mgfa_fifo
   import mgfa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type head
);

   localparam int PW = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
   localparam int CW = $clog2(JOB_DEPTH + 1);

   job_type         entry_ff [JOB_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   count_ff;
   logic            do_push, do_pop;

   assign full    = (count_ff == CW'(JOB_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // store the pushed job
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

   // advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push)
            wr_ptr_ff <= (wr_ptr_ff == PW'(JOB_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (do_pop)
            rd_ptr_ff <= (rd_ptr_ff == PW'(JOB_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         count_ff <= count_ff + CW'(do_push) - CW'(do_pop);
      end
   end

endmodule

/* rtl/mgfa_back.sv */
// Back end: walks the posted codes of one job and emits one result per cycle while the output register is free.
module mgfa_back
   import mgfa_pkg::*;
#(
   parameter int QUEUE_SLOTS = 5
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_empty,
   input  job_type job_head,
   output logic    job_pop,
   input  logic    rsp_pop,
   output logic    rsp_empty,
   output rsp_type rsp
);

   localparam int CW = $clog2(QUEUE_SLOTS + 8);

   logic                 work_valid_ff, work_valid_in;
   logic [NUM_CODES-1:0] mask_ff, mask_in, mask_next;
   logic [CW-1:0]        fill_ff, fill_in;
   logic [CW-1:0]        left_ff, left_in;
   job_type              job_ff, job_in;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_ff, out_in;
   logic                 out_free, emit, emit_last, load;
   logic [4:0]           code;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign emit      = work_valid_ff && out_free;
   assign load      = !job_empty && (!work_valid_ff || (emit && emit_last));
   assign job_pop   = load;
   assign rsp_empty = !out_valid_ff;
   assign rsp       = out_ff;

   // pick the lowest pending code and build the next result
   always_comb begin
      code = '0;
      for (int i = NUM_CODES - 1; i >= 0; i--) begin
         if (mask_ff[i]) code = 5'(i);
      end
      mask_next = mask_ff & ~(NUM_CODES'(1) << code);

      out_in.sat_lo = job_ff.sat_lo;
      out_in.sat_li = job_ff.sat_li;
      out_in.sat_ri = job_ff.sat_ri;
      out_in.sat_ro = job_ff.sat_ro;
      out_in.disc   = job_ff.disc;
      if (mask_ff == '0) begin
         out_in.msg_valid      = 1'b0;
         out_in.msg_code       = '0;
         out_in.msg_class      = '0;
         out_in.msg_slot       = '0;
         out_in.queue_fill_out = fill_ff[2:0];
         emit_last             = 1'b1;
      end else begin
         out_in.msg_valid      = 1'b1;
         out_in.msg_code       = code;
         out_in.msg_class      = code_class(code);
         out_in.msg_slot       = fill_ff[2:0];
         out_in.queue_fill_out = 3'(fill_ff + 1'b1);
         emit_last             = (mask_next == '0) || (left_ff == CW'(1));
      end
      out_in.last = emit_last;

      // hold or drop the output register
      if (emit) out_valid_in = 1'b1;
      else if (rsp_pop) out_valid_in = 1'b0;
      else out_valid_in = out_valid_ff;

      // advance the working job, or take the next one from the queue
      work_valid_in = work_valid_ff;
      mask_in       = mask_ff;
      fill_in       = fill_ff;
      left_in       = left_ff;
      job_in        = job_ff;
      if (emit) begin
         mask_in = mask_next;
         fill_in = fill_ff + 1'b1;
         left_in = left_ff - 1'b1;
         if (emit_last) work_valid_in = 1'b0;
      end
      if (load) begin
         work_valid_in = 1'b1;
         job_in        = job_head;
         mask_in       = job_head.post_mask;
         fill_in       = CW'(job_head.fill_in);
         left_in       = (CW'(job_head.fill_in) < CW'(QUEUE_SLOTS)) ?
                         CW'(QUEUE_SLOTS) - CW'(job_head.fill_in) : '0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      fill_ff <= fill_in;
      left_ff <= left_in;
      job_ff  <= job_in;
      if (emit) out_ff <= out_in;
   end

endmodule

/* rtl/mode_gated_fault_annunciator.sv */
// Top level of the mode-gated fault annunciator.
//
// Usage: one request transaction is one monitoring cycle (major mode, alert
// and engine bits, four elevon positions, current fault queue fill). It is
// taken when req_push is high and req_full is low. The block answers with one
// response transaction per posted fault message, in code order, up to the free
// fault queue slots, or a single response with rsp_msg_valid low when nothing
// is posted; rsp_last marks the final response of a cycle. A response is on
// the rsp_ ports while rsp_empty is low and is taken on rsp_pop. When the
// block is idle, a taken request passes the job queue, the working job
// register and the output register before its first response appears.
// Throughput: the back end emits one response per clock while the receiver
// takes them; the front end takes a request every clock while the two-entry
// job queue has room. The limit registers are written on csr_wr_en at any
// index 0 or 1. Reset clears the alert latches, the job queue and the output
// register's valid flag and loads the default saturation limits. A stalled
// receiver holds the current response; the job queue then fills and req_full rises.
module mode_gated_fault_annunciator
   import mgfa_pkg::*;
#(
   parameter int QUEUE_SLOTS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wr_data,
   input  logic        req_push,
   output logic        req_full,
   input  logic [9:0]  req_major_mode,
   input  logic [12:0] req_alert_bits,
   input  logic [11:0] req_engine_path_bits,
   input  logic [2:0]  req_engine_shutdown_bits,
   input  logic        req_meco_commanded,
   input  logic        req_weight_on_wheels,
   input  logic signed [15:0] req_pos_left_outboard,
   input  logic signed [15:0] req_pos_left_inboard,
   input  logic signed [15:0] req_pos_right_inboard,
   input  logic signed [15:0] req_pos_right_outboard,
   input  logic [2:0]  req_queue_fill_in,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_msg_valid,
   output logic [4:0]  rsp_msg_code,
   output logic [1:0]  rsp_msg_class,
   output logic [2:0]  rsp_msg_slot,
   output logic [2:0]  rsp_queue_fill_out,
   output logic [1:0]  rsp_sat_left_outboard,
   output logic [1:0]  rsp_sat_left_inboard,
   output logic [1:0]  rsp_sat_right_inboard,
   output logic [1:0]  rsp_sat_right_outboard,
   output logic [1:0]  rsp_discrete_set_bits,
   output logic        rsp_last
);

   job_type front_job, head_job;
   rsp_type rsp;
   logic    accept, job_empty, job_pop;

   assign accept = req_push && !req_full;

   // classify each request and update the latches
   mgfa_front #(.QUEUE_SLOTS(QUEUE_SLOTS)) u_front (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wr_data          (csr_wr_data),
      .accept               (accept),
      .major_mode           (req_major_mode),
      .alert_bits           (req_alert_bits),
      .engine_path_bits     (req_engine_path_bits),
      .engine_shutdown_bits (req_engine_shutdown_bits),
      .meco_commanded       (req_meco_commanded),
      .weight_on_wheels     (req_weight_on_wheels),
      .pos_left_outboard    (req_pos_left_outboard),
      .pos_left_inboard     (req_pos_left_inboard),
      .pos_right_inboard    (req_pos_right_inboard),
      .pos_right_outboard   (req_pos_right_outboard),
      .queue_fill_in        (req_queue_fill_in),
      .job                  (front_job)
   );

   // decouple front and back
   mgfa_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_job),
      .full      (req_full),
      .pop       (job_pop),
      .empty     (job_empty),
      .head      (head_job)
   );

   // emit the messages of each job
   mgfa_back #(.QUEUE_SLOTS(QUEUE_SLOTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_head  (head_job),
      .job_pop   (job_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp)
   );

   assign rsp_msg_valid          = rsp.msg_valid;
   assign rsp_msg_code           = rsp.msg_code;
   assign rsp_msg_class          = rsp.msg_class;
   assign rsp_msg_slot           = rsp.msg_slot;
   assign rsp_queue_fill_out     = rsp.queue_fill_out;
   assign rsp_sat_left_outboard  = rsp.sat_lo;
   assign rsp_sat_left_inboard   = rsp.sat_li;
   assign rsp_sat_right_inboard  = rsp.sat_ri;
   assign rsp_sat_right_outboard = rsp.sat_ro;
   assign rsp_discrete_set_bits  = rsp.disc;
   assign rsp_last               = rsp.last;

endmodule
